/* hw/rtl/wsu_pkg.sv */
`timescale 1ns / 1ps
package wsu_pkg;

  // Default width of the payload length counter
  localparam int unsigned LENGTH_BITS_DEF = 64;

  // 7-bit length codes that announce an extended length
  localparam logic [6:0] LEN7_EXT16 = 7'h7E;
  localparam logic [6:0] LEN7_EXT64 = 7'h7F;

  // Opcodes accepted as valid frames
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  // Last index of the extended length bytes and of the mask key bytes
  localparam logic [2:0] EXT16_LAST_IDX = 3'd1;
  localparam logic [2:0] EXT64_LAST_IDX = 3'd7;
  localparam logic [2:0] MASK_LAST_IDX  = 3'd3;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT16   = 3'd2,
    PH_EXT64   = 3'd3,
    PH_MASK    = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    ST_PAYLOAD = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_SKIPPED = 2'd2
  } status_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic [3:0] opcode;
    status_e    status;
    logic       last;
  } wsu_result_t;

  function automatic logic opcode_known(input logic [3:0] op);
    return (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BINARY) ||
           (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
  endfunction

endpackage

/* hw/rtl/wsu_parser.sv */
`timescale 1ns / 1ps
module wsu_parser #(
  parameter int unsigned LENGTH_BITS = wsu_pkg::LENGTH_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 beat_i,
  input  logic [7:0]           byte_i,
  output wsu_pkg::wsu_result_t result_o
);
  import wsu_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [2:0]             cnt_q, cnt_d;
  logic [3:0]             opcode_q, opcode_d;
  logic                   op_ok_q, op_ok_d;
  logic [LENGTH_BITS-1:0] rem_q, rem_d;
  logic [31:0]            key_q, key_d;
  logic [1:0]             pos_q, pos_d;

  logic [7:0] key_byte;
  logic [2:0] ext_last;
  logic       rem_zero;

  assign rem_zero = (rem_q == '0);
  assign ext_last = (phase_q == PH_EXT16) ? EXT16_LAST_IDX : EXT64_LAST_IDX;

  always_comb begin
    unique case (pos_q)
      2'd0: key_byte = key_q[31:24];
      2'd1: key_byte = key_q[23:16];
      2'd2: key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    opcode_d = opcode_q;
    op_ok_d  = op_ok_q;
    rem_d    = rem_q;
    key_d    = key_q;
    pos_d    = pos_q;
    result_o = '{valid: 1'b0, data: 8'h00, opcode: opcode_q,
                 status: ST_PAYLOAD, last: 1'b0};
    if (beat_i) begin
      unique case (phase_q)
        PH_HDR1: begin
          cnt_d = '0;
          rem_d = '0;
          if (byte_i[6:0] == LEN7_EXT16) begin
            phase_d = PH_EXT16;
          end else if (byte_i[6:0] == LEN7_EXT64) begin
            phase_d = PH_EXT64;
          end else begin
            rem_d   = LENGTH_BITS'(byte_i[6:0]);
            key_d   = '0;
            phase_d = PH_MASK;
          end
        end
        PH_EXT16, PH_EXT64: begin
          // shift the length in, most significant byte first
          rem_d = {rem_q[LENGTH_BITS-9:0], byte_i};
          if (cnt_q >= ext_last) begin
            cnt_d   = '0;
            key_d   = '0;
            phase_d = PH_MASK;
          end else begin
            cnt_d = cnt_q + 3'd1;
          end
        end
        PH_MASK: begin
          key_d = {key_q[23:0], byte_i};
          if (cnt_q < MASK_LAST_IDX) begin
            cnt_d = cnt_q + 3'd1;
          end else begin
            cnt_d   = '0;
            pos_d   = '0;
            phase_d = rem_zero ? PH_HDR0 : PH_PAYLOAD;
            if (!op_ok_q) begin
              result_o.valid  = 1'b1;
              result_o.status = ST_SKIPPED;
              result_o.last   = 1'b1;
            end else if (rem_zero) begin
              result_o.valid  = 1'b1;
              result_o.status = ST_EMPTY;
              result_o.last   = 1'b1;
            end
          end
        end
        PH_PAYLOAD: begin
          rem_d = rem_q - LENGTH_BITS'(1);
          pos_d = pos_q + 2'd1;
          if (rem_q == LENGTH_BITS'(1)) begin
            phase_d = PH_HDR0;
          end
          // drop payload of a skipped frame
          result_o.valid = op_ok_q;
          result_o.data  = byte_i ^ key_byte;
          result_o.last  = (rem_q == LENGTH_BITS'(1));
        end
        default: begin
          opcode_d = byte_i[3:0];
          op_ok_d  = opcode_known(byte_i[3:0]);
          cnt_d    = '0;
          phase_d  = PH_HDR1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      cnt_q    <= '0;
      opcode_q <= '0;
      op_ok_q  <= 1'b0;
      rem_q    <= '0;
      key_q    <= '0;
      pos_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      opcode_q <= opcode_d;
      op_ok_q  <= op_ok_d;
      rem_q    <= rem_d;
      key_q    <= key_d;
      pos_q    <= pos_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_mask_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_MASK) |-> (cnt_q <= MASK_LAST_IDX))
    else $error("mask key byte count overran");

  a_ext16_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_EXT16) |-> (cnt_q <= EXT16_LAST_IDX))
    else $error("16-bit length byte count overran");

  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (rem_q != '0))
    else $error("payload phase with no bytes left");
`endif

endmodule

/* hw/rtl/websocket_frame_unmasker.sv */
`timescale 1ns / 1ps
// WebSocket client frame unmasker. Feed the raw client-to-server stream one
// byte per beat on the slave side; the block parses the header (opcode,
// 7-bit length with 16- or 64-bit extension, four mask key bytes) and gives
// one master-side beat per payload byte, unmasked with key byte j mod 4 and
// marked with tlast on the final byte of the frame. Header bytes give no
// beat. A zero-length frame gives one beat with status "empty"; a frame with
// an opcode other than continuation, text, binary, close, ping or pong gives
// one beat with status "skipped" once its mask key is in, and its payload is
// then consumed and dropped. The mask bit is not checked. Throughput is one
// byte per clock cycle: the parser state advances once per accepted byte
// (the length counter decrement and zero test set the path), and the
// result lands in one output register in the cycle after the byte is
// taken. Downstream back-pressure is the only thing that stalls the input.
module websocket_frame_unmasker #(
  parameter int unsigned LENGTH_BITS = wsu_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side: tdata = in_byte[7:0]
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,
  // master side: tdata = data_byte[7:0], frame_opcode[11:8], zero pad[15:12]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,
  // tuser = status[1:0] (payload, empty, skipped)
  output logic [1:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);
  import wsu_pkg::*;

  wsu_result_t res;
  logic        in_beat;

  logic       out_valid_q;
  logic [7:0] out_data_q;
  logic [3:0] out_op_q;
  status_e    out_status_q;
  logic       out_last_q;

  // Take a new byte whenever the output slot is empty or drains this cycle
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;

  wsu_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .beat_i  (in_beat),
    .byte_i  (s_axis_tdata_i),
    .result_o(res)
  );

  // Output register: load on an accepted byte, otherwise hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= in_beat && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat && res.valid) begin
      out_data_q   <= res.data;
      out_op_q     <= res.opcode;
      out_status_q <= res.status;
      out_last_q   <= res.last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'h0, out_op_q, out_data_q};
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef NO_ASSERTIONS
  a_marker_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != ST_PAYLOAD)) |->
      (m_axis_tdata_o[7:0] == 8'h00) && m_axis_tlast_o)
    else $error("empty or skipped beat with data or without tlast");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o != 2'd3))
    else $error("undefined status on output");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("pending result lost");
`endif

endmodule
